@@ hdl/stn_pkg.sv @@
// Shared types and codes for the sorted timestamp table.
package stn_pkg;

  localparam int HANDLES = 16;
  localparam int HDL_W   = 4;
  localparam int POS_W   = 64;
  localparam int CNT_W   = 5;

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_REMOVE  = 2'd1;
  localparam logic [1:0] REQ_MOVE    = 2'd2;
  localparam logic [1:0] REQ_CLOSEST = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [HDL_W-1:0] handle;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [HDL_W-1:0] result_handle;
    logic [POS_W-1:0] result_position;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  // broadcast to every cell
  typedef struct packed {
    logic calc;
    logic apply;
    logic ins;
    logic del;
    logic closest;
    logic want_old;
  } ctl_t;

  // per-cell flags captured in the compare cycle
  typedef struct packed {
    logic occ;
    logic gt;
    logic lt;
    logic match;
    logic after;
  } flag_t;

endpackage

@@ hdl/stn_cell.sv @@
// One slot of the sorted table: compare, shift and nearest pick.
module stn_cell (
  input  logic                       clk,
  input  stn_pkg::ctl_t              ctl,
  input  logic [stn_pkg::POS_W-1:0]  p,
  input  logic [stn_pkg::HDL_W-1:0]  h,
  input  logic                       occ,
  input  logic                       occ_new,
  input  logic                       seen_in,
  output logic                       seen_out,
  input  logic [stn_pkg::POS_W-1:0]  prev_pos,
  input  logic [stn_pkg::HDL_W-1:0]  prev_hdl,
  input  stn_pkg::flag_t             prev_fl,
  input  logic [stn_pkg::POS_W-1:0]  next_pos,
  input  logic [stn_pkg::HDL_W-1:0]  next_hdl,
  input  stn_pkg::flag_t             next_fl,
  output logic [stn_pkg::POS_W-1:0]  pos,
  output logic [stn_pkg::HDL_W-1:0]  hdl,
  output stn_pkg::flag_t             fl,
  output logic [stn_pkg::POS_W-1:0]  res_pos,
  output logic [stn_pkg::HDL_W-1:0]  res_hdl
);

  logic                      gt_now;
  logic                      match_now;
  logic                      from_self;
  logic                      from_prev;
  logic                      from_next;
  logic                      take_new;
  logic [stn_pkg::POS_W-1:0] dp_self;
  logic [stn_pkg::POS_W-1:0] dn_self;
  logic [stn_pkg::POS_W-1:0] dp_prev;
  logic [stn_pkg::POS_W-1:0] dn_next;
  logic                      pick_lo;
  logic                      pick_hi;
  logic                      sel;

  function automatic logic geff(input stn_pkg::ctl_t c, input stn_pkg::flag_t f);
    return c.ins & f.gt & ~(c.del & f.match);
  endfunction

  function automatic logic aft(input stn_pkg::ctl_t c, input stn_pkg::flag_t f);
    return c.del & f.after;
  endfunction

  assign gt_now    = occ & (pos > p);
  assign match_now = occ & (hdl == h);
  assign seen_out  = seen_in | match_now;

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      fl.occ   <= occ;
      fl.gt    <= gt_now;
      fl.lt    <= occ & ~gt_now;
      fl.match <= match_now;
      fl.after <= seen_in;
    end
  end

  // source of the new content after a delete and/or insert
  assign from_self = fl.occ & ~(ctl.del & fl.match) & (geff(ctl, fl) == aft(ctl, fl));
  assign from_prev = prev_fl.occ & geff(ctl, prev_fl) & ~aft(ctl, prev_fl);
  assign from_next = next_fl.occ & aft(ctl, next_fl) & ~geff(ctl, next_fl);
  assign take_new  = ctl.ins & occ_new;

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      if (from_self) begin
        pos <= pos;
        hdl <= hdl;
      end else if (from_prev) begin
        pos <= prev_pos;
        hdl <= prev_hdl;
      end else if (from_next) begin
        pos <= next_pos;
        hdl <= next_hdl;
      end else if (take_new) begin
        pos <= p;
        hdl <= h;
      end
    end
  end

  // nearest: last entry <= p against first entry > p, tie to the lower
  assign dp_self = p - pos;
  assign dn_self = pos - p;
  assign dp_prev = p - prev_pos;
  assign dn_next = next_pos - p;

  assign pick_lo = fl.lt & ~next_fl.lt & (~next_fl.gt | (dp_self <= dn_next));
  assign pick_hi = fl.gt & ~prev_fl.gt & (~prev_fl.lt | (dp_prev > dn_self));

  assign sel     = (ctl.closest & (pick_lo | pick_hi)) | (ctl.want_old & fl.match);
  assign res_pos = sel ? pos : '0;
  assign res_hdl = sel ? hdl : '0;

endmodule

@@ hdl/sorted_timestamp_table_nearest.sv @@
// Top level of the sorted timestamp table with nearest-entry lookup.
//
// Request channel (req_valid, req_stall, req): one beat carries an add,
// remove, move or closest request. Response channel (rsp_valid, rsp_stall,
// rsp): exactly one beat per request, in request order, with status, handle,
// position and the entry count after the request.
// Entries live in a row of MAX_MARKERS cells kept in ascending order; at most
// 16 are ever in use since handles are 4 bits.
// Each request passes a compare state, where every cell compares its entry
// against the request and registers its flags, then an apply state, where all
// cells shift in parallel and the response register loads.
// No new request is taken in the compare state.
// The next request is taken in the same cycle the previous one is applied,
// so a pending response does not hold up the input side by itself.
// If rsp_stall is high with a response pending, the response register holds
// and the block waits in apply, stalling requests until the beat is taken.
// Reset (rst, synchronous) empties the table, frees all handles and drops
// any pending response; the block is ready in the cycle after reset.
module sorted_timestamp_table_nearest #(
  parameter int MAX_MARKERS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  stn_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output stn_pkg::rsp_t rsp
);

  localparam int NCELL = MAX_MARKERS;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CALC  = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t                              state;
  state_t                              state_next;
  stn_pkg::req_t                       req_q;
  logic [stn_pkg::CNT_W-1:0]           count;
  logic [stn_pkg::CNT_W-1:0]           count_new;
  logic [stn_pkg::HANDLES-1:0]         in_use;
  stn_pkg::rsp_t                       rsp_next;
  logic                                out_free;
  stn_pkg::ctl_t                       ctl;

  logic [stn_pkg::POS_W-1:0]           cell_pos [NCELL];
  logic [stn_pkg::HDL_W-1:0]           cell_hdl [NCELL];
  stn_pkg::flag_t                      cell_fl  [NCELL];
  logic [stn_pkg::POS_W-1:0]           cell_rpos[NCELL];
  logic [stn_pkg::HDL_W-1:0]           cell_rhdl[NCELL];
  logic [NCELL:0]                      seen;
  logic [NCELL-1:0]                    occ;
  logic [NCELL-1:0]                    occ_new;
  logic [NCELL-1:0]                    match_v;

  logic                                is_add;
  logic                                is_rem;
  logic                                is_move;
  logic                                is_closest;
  logic                                found;
  logic                                full;
  logic                                add_ok;
  logic                                rem_ok;
  logic [stn_pkg::HDL_W-1:0]           free_h;
  logic [stn_pkg::POS_W-1:0]           sel_pos;
  logic [stn_pkg::HDL_W-1:0]           sel_hdl;

  assign out_free  = ~rsp_valid | ~rsp_stall;
  assign req_stall = rst | ~((state == S_IDLE) | ((state == S_APPLY) & out_free));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_CALC;
      S_CALC:  state_next = S_APPLY;
      S_APPLY: begin
        if (out_free) state_next = req_valid ? S_CALC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  // request decode and outcome
  assign is_add     = req_q.req_type == stn_pkg::REQ_ADD;
  assign is_rem     = req_q.req_type == stn_pkg::REQ_REMOVE;
  assign is_move    = req_q.req_type == stn_pkg::REQ_MOVE;
  assign is_closest = req_q.req_type == stn_pkg::REQ_CLOSEST;

  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      match_v[i] = cell_fl[i].match;
    end
  end

  assign found  = |match_v;
  assign full   = (int'(count) >= MAX_MARKERS) | (&in_use);
  assign add_ok = is_add & ~full;
  assign rem_ok = is_rem & found;

  always_comb begin
    free_h = '0;
    for (int i = stn_pkg::HANDLES - 1; i >= 0; i--) begin
      if (!in_use[i]) free_h = stn_pkg::HDL_W'(i);
    end
  end

  assign count_new = count + stn_pkg::CNT_W'(add_ok) - stn_pkg::CNT_W'(rem_ok);

  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      occ[i]     = int'(count) > i;
      occ_new[i] = int'(count_new) > i;
    end
  end

  always_comb begin
    ctl.calc     = state == S_CALC;
    ctl.apply    = (state == S_APPLY) & out_free;
    ctl.ins      = add_ok | (is_move & found);
    ctl.del      = (is_rem | is_move) & found;
    ctl.closest  = is_closest;
    ctl.want_old = is_move;
  end

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    logic [stn_pkg::POS_W-1:0] prev_pos;
    logic [stn_pkg::HDL_W-1:0] prev_hdl;
    stn_pkg::flag_t            prev_fl;
    logic [stn_pkg::POS_W-1:0] next_pos;
    logic [stn_pkg::HDL_W-1:0] next_hdl;
    stn_pkg::flag_t            next_fl;

    if (g == 0) begin : g_first
      assign prev_pos = '0;
      assign prev_hdl = '0;
      assign prev_fl  = '0;
    end else begin : g_mid_lo
      assign prev_pos = cell_pos[g-1];
      assign prev_hdl = cell_hdl[g-1];
      assign prev_fl  = cell_fl[g-1];
    end

    if (g == NCELL - 1) begin : g_last
      assign next_pos = '0;
      assign next_hdl = '0;
      assign next_fl  = '0;
    end else begin : g_mid_hi
      assign next_pos = cell_pos[g+1];
      assign next_hdl = cell_hdl[g+1];
      assign next_fl  = cell_fl[g+1];
    end

    stn_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .p        (req_q.position),
      .h        (add_ok ? free_h : req_q.handle),
      .occ      (occ[g]),
      .occ_new  (occ_new[g]),
      .seen_in  (seen[g]),
      .seen_out (seen[g+1]),
      .prev_pos (prev_pos),
      .prev_hdl (prev_hdl),
      .prev_fl  (prev_fl),
      .next_pos (next_pos),
      .next_hdl (next_hdl),
      .next_fl  (next_fl),
      .pos      (cell_pos[g]),
      .hdl      (cell_hdl[g]),
      .fl       (cell_fl[g]),
      .res_pos  (cell_rpos[g]),
      .res_hdl  (cell_rhdl[g])
    );
  end

  always_comb begin
    sel_pos = '0;
    sel_hdl = '0;
    for (int i = 0; i < NCELL; i++) begin
      sel_pos = sel_pos | cell_rpos[i];
      sel_hdl = sel_hdl | cell_rhdl[i];
    end
  end

  always_comb begin
    rsp_next.status          = stn_pkg::ST_OK;
    rsp_next.result_handle   = '0;
    rsp_next.result_position = '0;
    rsp_next.entry_count     = count_new;
    unique case (req_q.req_type)
      stn_pkg::REQ_ADD: begin
        if (full) rsp_next.status = stn_pkg::ST_FULL;
        else rsp_next.result_handle = free_h;
      end
      stn_pkg::REQ_REMOVE, stn_pkg::REQ_MOVE: begin
        if (!found) begin
          rsp_next.status = stn_pkg::ST_NOT_FOUND;
        end else begin
          rsp_next.result_handle = req_q.handle;
          if (is_move) rsp_next.result_position = sel_pos;
        end
      end
      stn_pkg::REQ_CLOSEST: begin
        if (count == '0) begin
          rsp_next.status = stn_pkg::ST_EMPTY;
        end else begin
          rsp_next.result_handle   = sel_hdl;
          rsp_next.result_position = sel_pos;
        end
      end
      default: rsp_next.status = stn_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      in_use <= '0;
    end else if (ctl.apply) begin
      count <= count_new;
      if (add_ok) in_use[free_h] <= 1'b1;
      if (rem_ok) in_use[req_q.handle] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.apply) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_count_matches_handles: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(count))
    else $error("entry count differs from handles in use");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= stn_pkg::HANDLES)
    else $error("entry count above handle space");

  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> state == S_CALC)
    else $error("accepted request did not enter compare cycle");

  a_calc_to_apply: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |=> state == S_APPLY)
    else $error("compare cycle not followed by apply");

  a_stall_holds_apply: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && !out_free) |=> (state == S_APPLY && rsp_valid))
    else $error("apply left while response still stalled");
`endif

endmodule
